// ===== design/sorted_table_equal_range_search_assert.svh =====
// ----------------------------------------------------------------------------
// Sorted table equal-range search: assertion macros
// Shared assertion forms for the search block and its checker.
// ----------------------------------------------------------------------------
`ifndef SORTED_TABLE_EQUAL_RANGE_SEARCH_ASSERT_SVH
`define SORTED_TABLE_EQUAL_RANGE_SEARCH_ASSERT_SVH

// Check a property on the rising clock edge, skipped while reset is asserted.
`define STERS_ASSERT_RST(name, clk, rst_n, prop) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("sorted table search check failed");

// Check a property on the rising clock edge, also during reset.
`define STERS_ASSERT_ALWAYS(name, clk, prop) \
  name: assert property (@(posedge clk) (prop)) \
    else $error("sorted table search check failed");

`endif

// ===== design/sters_pkg.sv =====
// ----------------------------------------------------------------------------
// Sorted table equal-range search package
// Operation codes and fixed port widths.
// ----------------------------------------------------------------------------
package sters_pkg;

  // Fixed field widths of the ports
  localparam int OP_W    = 1;
  localparam int IDX_W   = 10;
  localparam int ITEM_W  = 32;
  localparam int CFG_W   = 11;

  // Operation codes of an input transaction
  localparam logic [OP_W-1:0] OP_WRITE  = 1'b0;
  localparam logic [OP_W-1:0] OP_SEARCH = 1'b1;

endpackage

// ===== design/sters_ram.sv =====
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
module sters_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== design/sorted_table_equal_range_search.sv =====
// ----------------------------------------------------------------------------
// Sorted table equal-range search
// Write transaction: stored in the accepting cycle, busy never rises, no result.
// Search transaction: each probe is a RAM read (ADDR), then a compare (CMP); one check
// state (ADDR with the range closed) ends each pass and DONE gives the result strobe;
// the next transaction is taken only after DONE, once the block is back in idle.
// A miss skips the second pass.
// The single RAM read port and its read latency set the probe rate.
// Reset (synchronous, active low) clears the sequencer and entries_r;
// the table itself is not cleared. The receiver cannot stall results.
// ----------------------------------------------------------------------------
module sorted_table_equal_range_search
  import sters_pkg::*;
#(
  parameter int TABLE_DEPTH = 1024,
  parameter int VALUE_WIDTH = 32
) (
  input  logic                     clk,
  input  logic                     rst_n,
  // configuration port
  input  logic                     cfg_wr_en,
  input  logic [CFG_W-1:0]         cfg_wr_data,
  // input transaction
  input  logic                     start,
  output logic                     busy,
  input  logic [OP_W-1:0]          in_operation,
  input  logic [IDX_W-1:0]         in_entry_index,
  input  logic signed [ITEM_W-1:0] in_item_value,
  // result transaction
  output logic                     out_valid,
  output logic                     out_found,
  output logic [IDX_W-1:0]         out_first_index,
  output logic [IDX_W-1:0]         out_last_index
);

  // RAM address width and a signed index width that holds -1 .. TABLE_DEPTH
  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int IW = AW + 2;

  // Sequencer: ADDR computes the midpoint and issues the read, CMP compares
  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_ADDR = 4'b0010,
    ST_CMP  = 4'b0100,
    ST_DONE = 4'b1000
  } state_t;

  state_t                  state_r, state_nxt;
  logic [CFG_W-1:0]        entries_r;

  // Search payload registers
  logic signed [VALUE_WIDTH-1:0] key_r, key_nxt;
  logic signed [IW-1:0]    low_r, low_nxt;
  logic signed [IW-1:0]    high_r, high_nxt;
  logic signed [IW-1:0]    top_r, top_nxt;     // n-1, upper bound for both passes
  logic signed [IW-1:0]    mid_r, mid_nxt;
  logic signed [IW-1:0]    hit_r, hit_nxt;     // last match; ends up as last index
  logic signed [IW-1:0]    first_r, first_nxt;
  logic                    hit_vld_r, hit_vld_nxt;
  logic                    phase_r, phase_nxt; // 0: leftmost pass, 1: rightmost pass
  logic                    found_r, found_nxt;

  // Input conditioning
  logic                    accept;
  logic signed [63:0]      item_ext;
  logic [VALUE_WIDTH-1:0]  item_val;
  logic [AW+IDX_W-1:0]     wr_idx_ext;
  logic                    wr_in_range;
  logic signed [IW-1:0]    n_sat;

  // Shared probe datapath
  logic signed [IW-1:0]    diff;
  logic signed [IW-1:0]    mid;
  logic                    range_open;
  logic                    ram_wr_en;
  logic                    ram_rd_en;
  logic [VALUE_WIDTH-1:0]  ram_rd_data;
  logic                    probe_eq;
  logic                    probe_gt;

  // Result index extraction (low bits of the index)
  logic [IW+IDX_W-1:0]     first_ext;
  logic [IW+IDX_W-1:0]     last_ext;

  assign accept = start && !busy;

  // Bring the 32-bit item to the table width: sign-extend or truncate
  assign item_ext    = 64'(in_item_value);
  assign item_val    = item_ext[VALUE_WIDTH-1:0];
  assign wr_idx_ext  = (AW + IDX_W)'(in_entry_index);
  assign wr_in_range = 32'(in_entry_index) < 32'(TABLE_DEPTH);

  // Clamp the configured count to the table depth
  assign n_sat = (32'(entries_r) > 32'(TABLE_DEPTH)) ? IW'(TABLE_DEPTH) : IW'(entries_r);

  // Midpoint low + (high - low) / 2; the difference is never negative when used
  assign range_open = (low_r <= high_r);
  assign diff       = high_r - low_r;
  assign mid        = low_r + (diff >>> 1);

  // Store writes only in idle; issue a read for each probe
  assign ram_wr_en = accept && (in_operation == OP_WRITE) && wr_in_range;
  assign ram_rd_en = (state_r == ST_ADDR) && range_open;

  sters_ram #(
    .WIDTH (VALUE_WIDTH),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (wr_idx_ext[AW-1:0]),
    .wr_data (item_val),
    .rd_en   (ram_rd_en),
    .rd_addr (mid[AW-1:0]),
    .rd_data (ram_rd_data)
  );

  // One signed comparator shared by every probe of both passes
  assign probe_eq = (key_r == $signed(ram_rd_data));
  assign probe_gt = (key_r > $signed(ram_rd_data));

  always_comb begin
    state_nxt   = state_r;
    key_nxt     = key_r;
    low_nxt     = low_r;
    high_nxt    = high_r;
    top_nxt     = top_r;
    mid_nxt     = mid_r;
    hit_nxt     = hit_r;
    first_nxt   = first_r;
    hit_vld_nxt = hit_vld_r;
    phase_nxt   = phase_r;
    found_nxt   = found_r;

    case (state_r)
      ST_IDLE: begin
        // Load a search; a write finishes in this cycle through the RAM port
        if (accept && (in_operation == OP_SEARCH)) begin
          key_nxt     = item_val;
          low_nxt     = '0;
          high_nxt    = n_sat - IW'(1);
          top_nxt     = n_sat - IW'(1);
          hit_vld_nxt = 1'b0;
          hit_nxt     = '0;
          first_nxt   = '0;
          phase_nxt   = 1'b0;
          found_nxt   = 1'b0;
          if (n_sat == '0) begin
            // Empty table: report not found right away
            state_nxt = ST_DONE;
          end else begin
            state_nxt = ST_ADDR;
          end
        end
      end

      ST_ADDR: begin
        if (range_open) begin
          // Hold the midpoint for the compare cycle; RAM data arrives next cycle
          mid_nxt   = mid;
          state_nxt = ST_CMP;
        end else if (!phase_r) begin
          // Leftmost pass over
          if (!hit_vld_r) begin
            found_nxt = 1'b0;
            first_nxt = '0;
            hit_nxt   = '0;
            state_nxt = ST_DONE;
          end else begin
            // Start the rightmost pass at the first hit; the hit stays as default last
            found_nxt = 1'b1;
            first_nxt = hit_r;
            low_nxt   = hit_r;
            high_nxt  = top_r;
            phase_nxt = 1'b1;
          end
        end else begin
          state_nxt = ST_DONE;
        end
      end

      ST_CMP: begin
        if (probe_eq) begin
          hit_nxt     = mid_r;
          hit_vld_nxt = 1'b1;
          if (phase_r) begin
            low_nxt = mid_r + IW'(1);
          end else begin
            high_nxt = mid_r - IW'(1);
          end
        end else if (probe_gt) begin
          low_nxt = mid_r + IW'(1);
        end else begin
          high_nxt = mid_r - IW'(1);
        end
        state_nxt = ST_ADDR;
      end

      ST_DONE: begin
        // Result strobe lasts this one cycle
        state_nxt = ST_IDLE;
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      entries_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (cfg_wr_en) begin
        entries_r <= cfg_wr_data;
      end
    end
  end

  // Search payload
  always_ff @(posedge clk) begin
    key_r     <= key_nxt;
    low_r     <= low_nxt;
    high_r    <= high_nxt;
    top_r     <= top_nxt;
    mid_r     <= mid_nxt;
    hit_r     <= hit_nxt;
    first_r   <= first_nxt;
    hit_vld_r <= hit_vld_nxt;
    phase_r   <= phase_nxt;
    found_r   <= found_nxt;
  end

  // Report indices in their low bits
  assign first_ext = (IW + IDX_W)'(unsigned'(first_r));
  assign last_ext  = (IW + IDX_W)'(unsigned'(hit_r));

  assign busy            = (state_r != ST_IDLE);
  assign out_valid       = (state_r == ST_DONE);
  assign out_found       = found_r;
  assign out_first_index = first_ext[IDX_W-1:0];
  assign out_last_index  = last_ext[IDX_W-1:0];

endmodule

// ===== design/sters_checker.sv =====
// ----------------------------------------------------------------------------
// Sorted table equal-range search checker
// Port-level checks on transaction sequencing and result encoding.
// ----------------------------------------------------------------------------
`include "sorted_table_equal_range_search_assert.svh"

module sters_checker
  import sters_pkg::*;
(
  input logic                     clk,
  input logic                     rst_n,
  input logic                     start,
  input logic                     busy,
  input logic [OP_W-1:0]          in_operation,
  input logic                     out_valid,
  input logic                     out_found,
  input logic [IDX_W-1:0]         out_first_index,
  input logic [IDX_W-1:0]         out_last_index
);

  // A result only appears while a search transaction is in flight
  `STERS_ASSERT_RST(a_result_while_busy, clk, rst_n, out_valid |-> busy)

  // One strobe per search transaction
  `STERS_ASSERT_RST(a_single_strobe, clk, rst_n, out_valid |=> !out_valid)

  // A miss reports both indices as zero
  `STERS_ASSERT_RST(a_miss_zero_idx, clk, rst_n,
    (out_valid && !out_found) |-> (out_first_index == '0 && out_last_index == '0))

  // A write transaction never makes the block busy
  `STERS_ASSERT_RST(a_write_no_busy, clk, rst_n,
    (start && !busy && in_operation == OP_WRITE) |=> !busy)

  // Busy rises only after an accepted search transaction
  `STERS_ASSERT_RST(a_busy_from_search, clk, rst_n,
    $rose(busy) |-> $past(start && in_operation == OP_SEARCH))

endmodule

bind sorted_table_equal_range_search sters_checker u_sters_checker (.*);

// ===== dv/sorted_table_equal_range_search_checker.sv =====
// ----------------------------------------------------------------------------
// Sorted table equal-range search: transaction checker
// Watches the command and result channels and keeps its own copy of the
// value table and the entry count. It predicts each search outcome with the
// two probe passes and compares every result strobe with the oldest
// outstanding prediction.
// ----------------------------------------------------------------------------
module sorted_table_equal_range_search_checker
  import sters_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cfg_wr_en,
  input  logic [CFG_W-1:0]         cfg_wr_data,
  input  logic                     start,
  input  logic                     busy,
  input  logic [OP_W-1:0]          in_operation,
  input  logic [IDX_W-1:0]         in_entry_index,
  input  logic signed [ITEM_W-1:0] in_item_value,
  input  logic                     out_valid,
  input  logic                     out_found,
  input  logic [IDX_W-1:0]         out_first_index,
  input  logic [IDX_W-1:0]         out_last_index,
  output int                       mismatch_count,
  output int                       pending_results,
  output int                       searches_checked
);

  localparam int SLOTS = 1024;

  typedef struct packed {
    logic             found;
    logic [IDX_W-1:0] first_index;
    logic [IDX_W-1:0] last_index;
  } span_t;

  logic signed [ITEM_W-1:0] value_store [SLOTS];
  logic [CFG_W-1:0]         entry_count;
  span_t                    span_queue [$];
  int                       errors = 0;
  int                       checked = 0;
  int                       outstanding = 0;

  assign mismatch_count   = errors;
  assign pending_results  = outstanding;
  assign searches_checked = checked;

  // Binary search over [lo, hi]; on a hit, record it and keep moving.
  function automatic int probe_pass(input logic signed [ITEM_W-1:0] target,
                                    input int lo, input int hi, input bit go_right);
    int hit;
    int mid;
    logic signed [ITEM_W-1:0] probe;
    hit = -1;
    while (lo <= hi) begin
      mid = lo + (hi - lo) / 2;
      probe = value_store[mid];
      if (probe == target) begin
        hit = mid;
        if (go_right) lo = mid + 1;
        else hi = mid - 1;
      end else if (target > probe) begin
        lo = mid + 1;
      end else begin
        hi = mid - 1;
      end
    end
    return hit;
  endfunction

  function automatic span_t predict_range(input logic signed [ITEM_W-1:0] target);
    int    n;
    int    first;
    int    last;
    span_t r;
    r = '0;
    n = (entry_count > SLOTS) ? SLOTS : int'(entry_count);
    if (n > 0) begin
      first = probe_pass(target, 0, n - 1, 1'b0);
      if (first >= 0) begin
        last = probe_pass(target, first, n - 1, 1'b1);
        if (last < 0) last = first;
        r.found       = 1'b1;
        r.first_index = first[IDX_W-1:0];
        r.last_index  = last[IDX_W-1:0];
      end
    end
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    errors++;
    if (errors <= 100)
      $display("mismatch at %0t: %s got %0d, expected %0d", $time, what, got, want);
  endtask

  always @(posedge clk) begin
    span_t want;
    if (!rst_n) begin
      entry_count = '0;
      span_queue.delete();
    end else begin
      if (cfg_wr_en === 1'b1) entry_count = cfg_wr_data;
      if (out_valid === 1'b1) begin
        if (span_queue.size() == 0) begin
          report_mismatch("result strobe with no search outstanding", 1, 0);
        end else begin
          want = span_queue.pop_front();
          checked++;
          if (out_found !== want.found)
            report_mismatch("found", out_found, want.found);
          if (out_first_index !== want.first_index)
            report_mismatch("first_index", out_first_index, want.first_index);
          if (out_last_index !== want.last_index)
            report_mismatch("last_index", out_last_index, want.last_index);
        end
      end
      if (start === 1'b1 && busy === 1'b0) begin
        if (in_operation == OP_WRITE) value_store[in_entry_index] = in_item_value;
        else span_queue.push_back(predict_range(in_item_value));
      end
    end
    outstanding <= span_queue.size();
  end

endmodule

// ===== dv/sorted_table_equal_range_search_tb.sv =====
// ----------------------------------------------------------------------------
// Sorted table equal-range search: testbench top
// Drives table writes and searches through the start/busy command port and
// sets the entry count between phases. A directed opening covers the empty
// table, value extremes, duplicate runs and an unsorted table; random phases
// follow with sorted, duplicate-heavy and scrambled tables, a full 1024-entry
// fill and counts above the table depth. The checker predicts and compares.
// ----------------------------------------------------------------------------
module sorted_table_equal_range_search_tb;
  import sters_pkg::*;

  localparam int TABLE_SLOTS   = 1024;
  localparam int RANDOM_ITEMS  = 1700;
  // Settle time after the last result, longer than a search of the full table.
  localparam int SETTLE_CYCLES = 64;
  localparam logic signed [ITEM_W-1:0] VALUE_MIN = 32'sh8000_0000;
  localparam logic signed [ITEM_W-1:0] VALUE_MAX = 32'sh7fff_ffff;

  logic                     clk = 1'b0;
  logic                     rst_n = 1'b0;
  logic                     cfg_wr_en = 1'b0;
  logic [CFG_W-1:0]         cfg_wr_data = '0;
  logic                     start = 1'b0;
  logic                     busy;
  logic [OP_W-1:0]          in_operation = OP_WRITE;
  logic [IDX_W-1:0]         in_entry_index = '0;
  logic signed [ITEM_W-1:0] in_item_value = '0;
  logic                     out_valid;
  logic                     out_found;
  logic [IDX_W-1:0]         out_first_index;
  logic [IDX_W-1:0]         out_last_index;

  int mismatch_count;
  int pending_results;
  int searches_checked;

  // Stimulus-side view of the table, used only to aim searches at stored
  // values and to know which entries are safe to probe.
  logic signed [ITEM_W-1:0] staged_value [TABLE_SLOTS];
  bit                       staged_loaded [TABLE_SLOTS];

  int idle_pct = 0;
  int item_count = 0;
  int write_count = 0;
  int setting_count = 0;

  sorted_table_equal_range_search DUT (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data),
    .start           (start),
    .busy            (busy),
    .in_operation    (in_operation),
    .in_entry_index  (in_entry_index),
    .in_item_value   (in_item_value),
    .out_valid       (out_valid),
    .out_found       (out_found),
    .out_first_index (out_first_index),
    .out_last_index  (out_last_index)
  );

  sorted_table_equal_range_search_checker range_check (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data),
    .start            (start),
    .busy             (busy),
    .in_operation     (in_operation),
    .in_entry_index   (in_entry_index),
    .in_item_value    (in_item_value),
    .out_valid        (out_valid),
    .out_found        (out_found),
    .out_first_index  (out_first_index),
    .out_last_index   (out_last_index),
    .mismatch_count   (mismatch_count),
    .pending_results  (pending_results),
    .searches_checked (searches_checked)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Hard stop in case the block hangs or a result never shows up.
  initial begin
    #(15_000_000);
    $display("status: fail");
    $finish;
  end

  // Present one transaction. Insert random idle cycles first, then hold
  // start high until an edge sees busy low; that edge accepts it. Leave
  // start high on return so back-to-back transactions need no gap.
  task automatic send_item(input logic [OP_W-1:0] op, input logic [IDX_W-1:0] idx,
                           input logic signed [ITEM_W-1:0] val);
    while ($urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start          <= 1'b1;
    in_operation   <= op;
    in_entry_index <= idx;
    in_item_value  <= val;
    @(posedge clk);
    while (busy) @(posedge clk);
    item_count++;
  endtask

  task automatic load_entry(input logic [IDX_W-1:0] idx,
                            input logic signed [ITEM_W-1:0] val);
    send_item(OP_WRITE, idx, val);
    staged_value[idx]  = val;
    staged_loaded[idx] = 1'b1;
    write_count++;
  endtask

  // The entry index of a search is ignored by the block; randomize it anyway.
  task automatic search_for(input logic signed [ITEM_W-1:0] target);
    send_item(OP_SEARCH, IDX_W'($urandom_range(0, TABLE_SLOTS - 1)), target);
  endtask

  // Drop start, wait for every outstanding result, let the block settle,
  // then write the entry count. The register is only touched while idle.
  task automatic set_entry_count(input int n);
    start <= 1'b0;
    @(posedge clk);
    while (pending_results != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= CFG_W'(n);
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    setting_count++;
  endtask

  // Load entries 0..m-1 non-decreasing: random start, random step size
  // class, a random share of duplicates, saturating at the top value.
  task automatic build_sorted(input int m);
    longint      level;
    int unsigned step_cap;
    int          dup_pct;
    int          i;
    case ($urandom_range(0, 3))
      0: step_cap = 2;
      1: step_cap = 200;
      2: step_cap = 1 << 20;
      default: step_cap = 1 << 28;
    endcase
    dup_pct = $urandom_range(0, 70);
    if ($urandom_range(0, 3) == 0) level = VALUE_MIN;
    else level = longint'(int'($urandom()));
    for (i = 0; i < m; i++) begin
      if (i > 0 && $urandom_range(0, 99) >= dup_pct) level += $urandom_range(1, step_cap);
      if (level > VALUE_MAX) level = VALUE_MAX;
      load_entry(IDX_W'(i), level[ITEM_W-1:0]);
    end
  endtask

  // Load entries 0..m-1 in no order; half from a tiny set so searches hit.
  task automatic build_scrambled(input int m);
    logic signed [ITEM_W-1:0] v;
    int                       i;
    for (i = 0; i < m; i++) begin
      if ($urandom_range(0, 1)) v = $urandom_range(0, 6) - 3;
      else v = $urandom();
      load_entry(IDX_W'(i), v);
    end
  endtask

  // Aim mostly at stored values, then at their neighbors and the extremes.
  function automatic logic signed [ITEM_W-1:0] pick_target(input int m);
    logic signed [ITEM_W-1:0] near;
    int                       r;
    r = $urandom_range(0, 99);
    near = (m > 0) ? staged_value[$urandom_range(0, m - 1)] : $urandom();
    if (r < 60) return near;
    if (r < 70) return near + 1;
    if (r < 78) return near - 1;
    if (r < 84) return VALUE_MIN;
    if (r < 90) return VALUE_MAX;
    return $urandom();
  endfunction

  initial begin
    int directed_items;
    int phase;
    int n;
    int m;
    int r;
    int i;
    bit full;

    // Hold reset, then release it once for the whole run.
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // ---------------- directed opening ----------------
    // Empty table after reset: nothing may be found, whatever the target.
    search_for(VALUE_MIN);
    send_item(OP_SEARCH, '1, VALUE_MAX);

    // Top slot (index all ones), then a short table with a duplicate run
    // and both value extremes at its ends.
    load_entry('1, VALUE_MAX);
    load_entry(10'd0, VALUE_MIN);
    load_entry(10'd1, -32'sd1);
    load_entry(10'd2, -32'sd1);
    load_entry(10'd3, -32'sd1);
    load_entry(10'd4, VALUE_MAX);

    // Single-entry table.
    set_entry_count(1);
    search_for(VALUE_MIN);
    search_for(-32'sd1);

    // Five entries: run in the middle, lone values at the ends, absent values.
    set_entry_count(5);
    search_for(-32'sd1);
    search_for(VALUE_MIN);
    search_for(VALUE_MAX);
    search_for(32'sd0);
    search_for(-32'sd2);

    // Unsorted contents: the first pass hits at index 1, the second pass
    // walks right past it and never hits, so last equals first.
    load_entry(10'd0, 32'sd0);
    load_entry(10'd1, 32'sd5);
    load_entry(10'd2, 32'sd1);
    load_entry(10'd3, 32'sd2);
    set_entry_count(4);
    search_for(32'sd5);
    search_for(32'sd2);
    directed_items = item_count;

    // ---------------- random phases ----------------
    // Rotate sender idling per phase: none, heavy (84%), light (19%).
    // Early phases stay small; phase 3 fills all 1024 slots sorted, then
    // counts above the depth and the tiny counts are forced once each.
    phase = 0;
    while (item_count - directed_items < RANDOM_ITEMS) begin
      if (phase == 3) n = TABLE_SLOTS;
      else if (phase == 4) n = 2047;
      else if (phase == 5) n = TABLE_SLOTS + 1;
      else if (phase == 6) n = 0;
      else if (phase == 7) n = 1;
      else if (phase == 8) n = 2;
      else if (phase < 3) n = $urandom_range(3, 48);
      else begin
        r = $urandom_range(0, 99);
        if (r < 5) n = 0;
        else if (r < 10) n = 1;
        else if (r < 15) n = 2;
        else if (r < 30) n = $urandom_range(65, 2047);
        else n = $urandom_range(3, 48);
      end
      m = (n > TABLE_SLOTS) ? TABLE_SLOTS : n;
      set_entry_count(n);
      idle_pct = (phase % 3 == 0) ? 0 : (phase % 3 == 1) ? 84 : 19;

      // Rebuild small windows, and any window that holds unwritten slots,
      // so no search can probe an entry never written. Large windows that
      // are already loaded only get a few random overwrites.
      full = 1'b1;
      for (i = 0; i < m; i++) full &= staged_loaded[i];
      if (m > 0) begin
        if (m <= 64 || !full) begin
          if (phase > 8 && $urandom_range(0, 99) < 15) build_scrambled(m);
          else build_sorted(m);
        end else begin
          repeat ($urandom_range(1, 4))
            load_entry(IDX_W'($urandom_range(0, m - 1)), $urandom());
        end
      end

      // Noise writes outside the searched window.
      if (m < TABLE_SLOTS) begin
        repeat ($urandom_range(0, 2))
          load_entry(IDX_W'($urandom_range(m, TABLE_SLOTS - 1)), $urandom());
      end

      repeat ((m > 64) ? 30 : $urandom_range(10, 40)) search_for(pick_target(m));
      phase++;
    end

    // ---------------- wind down ----------------
    // Drop start, wait for every outstanding result, then settle.
    start <= 1'b0;
    @(posedge clk);
    while (pending_results != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("covered %0d checked searches, %0d table writes, %0d entry-count settings",
             searches_checked, write_count, setting_count);
    $display("tables: empty, extremes, duplicate runs, full 1024 fill, count above depth, unsorted");
    if (mismatch_count == 0 && pending_results == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
